// ===== rtl/dpc_pkg.sv =====
// shared constants and helpers for the decimal palindrome check pipeline
// no dependencies
`default_nettype none

package dpc_pkg;

	localparam int DEF_VALUE_BITS = 32;
	localparam int DIGIT_BITS     = 4;
	localparam int DD_STEP_BITS   = 8;

	localparam logic [DIGIT_BITS-1:0] DD_THRESH = 4'd5;
	localparam logic [DIGIT_BITS-1:0] DD_ADJ    = 4'd3;

	// decimal digits needed for a magnitude up to 2^(bits-1), never too few
	function automatic int num_digits(input int bits);
		return ((bits - 1) * 30103) / 100000 + 1;
	endfunction

	// shift-and-add-3 correction of one bcd digit
	function automatic logic [DIGIT_BITS-1:0] dd_adjust(input logic [DIGIT_BITS-1:0] d);
		logic [DIGIT_BITS-1:0] r;
		r = d;
		if (d >= DD_THRESH) begin
			r = d + DD_ADJ;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dpc_ifs.sv =====
// valid/ready channel interfaces for the decimal palindrome check
// depends on dpc_pkg
`default_nettype none

interface dpc_in_if
	import dpc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic                         is_last;

	modport source (output valid, value, is_last, input ready);
	modport sink (input valid, value, is_last, output ready);
endinterface

interface dpc_out_if
	import dpc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value_echo;
	logic                         is_palindrome;
	logic                         last_out;

	modport source (output valid, value_echo, is_palindrome, last_out, input ready);
	modport sink (input valid, value_echo, is_palindrome, last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpc_dd_stage.sv =====
// one pipeline stage of the binary to bcd conversion (shift and add 3)
// depends on dpc_pkg
`default_nettype none

module dpc_dd_stage
	import dpc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int NUM_DIGITS = num_digits(DEF_VALUE_BITS),
	parameter int STEPS      = DD_STEP_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [VALUE_BITS-1:0]              in_bin,
	input  wire logic [NUM_DIGITS*DIGIT_BITS-1:0]   in_bcd,
	input  wire logic [VALUE_BITS-1:0]              in_value,
	input  wire logic                               in_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [VALUE_BITS-1:0]                   out_bin,
	output logic [NUM_DIGITS*DIGIT_BITS-1:0]        out_bcd,
	output logic [VALUE_BITS-1:0]                   out_value,
	output logic                                    out_last
);

	localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] bin_s1;
	logic [BCD_BITS-1:0]   bcd_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  last_s1;
	logic [VALUE_BITS-1:0] bin_nx;
	logic [BCD_BITS-1:0]   bcd_nx;

	always_comb begin
		bin_nx = in_bin;
		bcd_nx = in_bcd;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				bcd_nx[d*DIGIT_BITS +: DIGIT_BITS] = dd_adjust(bcd_nx[d*DIGIT_BITS +: DIGIT_BITS]);
			end
			bcd_nx = {bcd_nx[BCD_BITS-2:0], bin_nx[VALUE_BITS-1]};
			bin_nx = {bin_nx[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bin_s1   <= bin_nx;
			bcd_s1   <= bcd_nx;
			value_s1 <= in_value;
			last_s1  <= in_last;
		end
	end

	assign out_valid = valid_s1;
	assign out_bin   = bin_s1;
	assign out_bcd   = bcd_s1;
	assign out_value = value_s1;
	assign out_last  = last_s1;

endmodule

`default_nettype wire

// ===== rtl/dpc_sym_check.sv =====
// digit count and mirror compare of the bcd digits, two pipeline stages
// depends on dpc_pkg
`default_nettype none

module dpc_sym_check
	import dpc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int NUM_DIGITS = num_digits(DEF_VALUE_BITS)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [NUM_DIGITS*DIGIT_BITS-1:0] in_bcd,
	input  wire logic [VALUE_BITS-1:0]            in_value,
	input  wire logic                             in_last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [VALUE_BITS-1:0]                 out_value,
	output logic                                  out_pal,
	output logic                                  out_last
);

	localparam int LEN_BITS = $clog2(NUM_DIGITS + 1);
	localparam int LEN_CNT  = 2 ** LEN_BITS;

	logic                  valid_s1;
	logic [LEN_BITS-1:0]   len_s1;
	logic [LEN_CNT-1:0]    eq_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  last_s1;
	logic                  ready_s1;

	logic                  valid_s2;
	logic                  pal_s2;
	logic [VALUE_BITS-1:0] value_s2;
	logic                  last_s2;

	logic [LEN_BITS-1:0]   len_nx;
	logic [LEN_CNT-1:0]    eq_nx;

	// digit count: one past the highest nonzero digit
	always_comb begin
		len_nx = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (in_bcd[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
				len_nx = LEN_BITS'(i + 1);
			end
		end
	end

	// mirror match for every possible digit count
	always_comb begin
		eq_nx = '0;
		for (int l = 0; l <= NUM_DIGITS; l++) begin
			eq_nx[l] = 1'b1;
			for (int i = 0; i < l / 2; i++) begin
				if (in_bcd[i*DIGIT_BITS +: DIGIT_BITS] != in_bcd[(l-1-i)*DIGIT_BITS +: DIGIT_BITS]) begin
					eq_nx[l] = 1'b0;
				end
			end
		end
	end

	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			len_s1   <= len_nx;
			eq_s1    <= eq_nx;
			value_s1 <= in_value;
			last_s1  <= in_last;
		end
		if (valid_s1 && ready_s1) begin
			pal_s2   <= eq_s1[len_s1];
			value_s2 <= value_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_value = value_s2;
	assign out_pal   = pal_s2;
	assign out_last  = last_s2;

endmodule

`default_nettype wire

// ===== rtl/decimal_palindrome_check_unit.sv =====
// Decimal palindrome check. Takes one signed value per word and returns one word with the
// value, a flag that is 1 when the decimal digits of its magnitude read the same both ways
// (zero and single digits count), and the last mark. Fully pipelined: a word can enter every
// cycle unless back-pressure holds it. The pipeline is one magnitude stage, one shift-and-add-3
// stage per 8 bits, then digit count and mirror compare. Back-pressure holds every stage.
// depends on dpc_pkg, dpc_ifs, dpc_dd_stage, dpc_sym_check
`default_nettype none

module decimal_palindrome_check_unit
	import dpc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dpc_in_if.sink     in_ch,
	dpc_out_if.source  out_ch
);

	localparam int NUM_DIGITS = num_digits(VALUE_BITS);
	localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;
	localparam int N_DD       = (VALUE_BITS + DD_STEP_BITS - 1) / DD_STEP_BITS;

	logic [N_DD:0]         dd_valid;
	logic [N_DD:0]         dd_ready;
	logic [VALUE_BITS-1:0] dd_bin   [N_DD+1];
	logic [BCD_BITS-1:0]   dd_bcd   [N_DD+1];
	logic [VALUE_BITS-1:0] dd_value [N_DD+1];
	logic [N_DD:0]         dd_last;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  last_s1;
	logic [VALUE_BITS-1:0] mag_nx;
	logic [VALUE_BITS-1:0] out_value;

	// magnitude, the most negative value maps to 2^(VALUE_BITS-1) exactly
	always_comb begin
		mag_nx = in_ch.value;
		if (in_ch.value[VALUE_BITS-1]) begin
			mag_nx = ~in_ch.value + VALUE_BITS'(1);
		end
	end

	assign in_ch.ready = !valid_s1 || dd_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mag_s1   <= mag_nx;
			value_s1 <= in_ch.value;
			last_s1  <= in_ch.is_last;
		end
	end

	assign dd_valid[0] = valid_s1;
	assign dd_bin[0]   = mag_s1;
	assign dd_bcd[0]   = '0;
	assign dd_value[0] = value_s1;
	assign dd_last[0]  = last_s1;

	for (genvar k = 0; k < N_DD; k++) begin : g_dd
		localparam int LEFT  = VALUE_BITS - k * DD_STEP_BITS;
		localparam int STEPS = (LEFT < DD_STEP_BITS) ? LEFT : DD_STEP_BITS;

		dpc_dd_stage #(
			.VALUE_BITS (VALUE_BITS),
			.NUM_DIGITS (NUM_DIGITS),
			.STEPS      (STEPS)
		) u_dd (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dd_valid[k]),
			.in_ready  (dd_ready[k]),
			.in_bin    (dd_bin[k]),
			.in_bcd    (dd_bcd[k]),
			.in_value  (dd_value[k]),
			.in_last   (dd_last[k]),
			.out_valid (dd_valid[k+1]),
			.out_ready (dd_ready[k+1]),
			.out_bin   (dd_bin[k+1]),
			.out_bcd   (dd_bcd[k+1]),
			.out_value (dd_value[k+1]),
			.out_last  (dd_last[k+1])
		);
	end

	dpc_sym_check #(
		.VALUE_BITS (VALUE_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_sym (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dd_valid[N_DD]),
		.in_ready  (dd_ready[N_DD]),
		.in_bcd    (dd_bcd[N_DD]),
		.in_value  (dd_value[N_DD]),
		.in_last   (dd_last[N_DD]),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_value (out_value),
		.out_pal   (out_ch.is_palindrome),
		.out_last  (out_ch.last_out)
	);

	assign out_ch.value_echo = out_value;

endmodule

`default_nettype wire

// ===== tb/decimal_palindrome_check_unit_test.sv =====
// self-checking testbench for decimal_palindrome_check_unit: a directed table, then random words
// with idle gaps and back-pressure; unfixed verdicts are predicted from the decimal digits of the magnitude
// depends on dpc_pkg, dpc_ifs and the decimal_palindrome_check_unit rtl
module decimal_palindrome_check_unit_test;
	import dpc_pkg::*;

	localparam int VB            = DEF_VALUE_BITS;
	localparam int SETTLE_CYCLES = 3 + (VB + 7) / 8 + 8;
	localparam int RANDOM_WORDS  = 700;
	localparam int LONG_HOLD     = 160;
	localparam int RUN_LIMIT     = 12 * 200000;

	typedef logic signed [VB-1:0] word_t;

	typedef struct {
		word_t value;
		logic  pal;
		logic  mark;
	} verdict_t;

	typedef struct {
		word_t value;
		logic  mark;
		logic  fixed;
		logic  pal;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dpc_in_if  #(.VALUE_BITS(VB)) in_ch ();
	dpc_out_if #(.VALUE_BITS(VB)) out_ch ();

	decimal_palindrome_check_unit #(.VALUE_BITS(VB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	verdict_t pending_verdicts [$];
	int       fails    = 0;
	logic     gapless  = 1'b0;
	logic     hold_req = 1'b0;

	// fixed rows carry a verdict that is obvious; the rest go through the predictor
	stim_row_t directed_rows [22] = '{
		'{32'sd0,           1'b0, 1'b1, 1'b1},
		'{32'sd7,           1'b0, 1'b1, 1'b1},
		'{-32'sd7,          1'b0, 1'b1, 1'b1},
		'{-32'sd1,          1'b0, 1'b1, 1'b1},
		'{32'sd9,           1'b1, 1'b1, 1'b1},
		'{32'sh7fffffff,    1'b0, 1'b1, 1'b0},
		'{32'sh80000000,    1'b0, 1'b1, 1'b0},
		'{32'sh80000001,    1'b1, 1'b1, 1'b0},
		'{32'sd10,          1'b0, 1'b0, 1'b0},
		'{32'sd11,          1'b0, 1'b0, 1'b0},
		'{32'sd100,         1'b0, 1'b0, 1'b0},
		'{32'sd101,         1'b0, 1'b0, 1'b0},
		'{-32'sd121,        1'b0, 1'b0, 1'b0},
		'{32'sd1221,        1'b0, 1'b0, 1'b0},
		'{32'sd12321,       1'b1, 1'b0, 1'b0},
		'{32'sd1000000001,  1'b0, 1'b0, 1'b0},
		'{-32'sd1000000001, 1'b0, 1'b0, 1'b0},
		'{32'sd2147447412,  1'b0, 1'b0, 1'b0},
		'{-32'sd2147447412, 1'b0, 1'b0, 1'b0},
		'{32'sd1000000000,  1'b0, 1'b0, 1'b0},
		'{32'sd1999999991,  1'b0, 1'b0, 1'b0},
		'{32'sd2147483646,  1'b1, 1'b0, 1'b0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic digits_mirror(input word_t v);
		logic [VB-1:0] mag;
		logic [3:0]    dig [0:19];
		int            n;
		int            lo;
		int            hi;
		logic          ok;
		mag = v;
		if (mag[VB-1]) begin
			mag = ~mag + 1'b1;
		end
		n = 0;
		while (mag != 0) begin
			dig[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end
		ok = 1'b1;
		lo = 0;
		hi = n - 1;
		while (lo < hi) begin
			if (dig[lo] != dig[hi]) begin
				ok = 1'b0;
			end
			lo++;
			hi--;
		end
		return ok;
	endfunction

	// builds a palindromic value of len digits; ten digits start with 1 to stay in range
	function automatic word_t mirror_value(input int len, input logic neg);
		longint unsigned acc;
		int              d [0:9];
		int              i;
		for (i = 0; i < len; i++) begin
			d[i] = (i == 0) ? $urandom_range(9, 1) : $urandom_range(9, 0);
		end
		if (len == 10) begin
			d[0] = 1;
		end
		for (i = 0; i < len / 2; i++) begin
			d[len-1-i] = d[i];
		end
		acc = 0;
		for (i = 0; i < len; i++) begin
			acc = acc * 10 + longint'(d[i]);
		end
		return neg ? -word_t'(acc) : word_t'(acc);
	endfunction

	task automatic offer_word(input word_t v, input logic mark, input logic fixed, input logic pal);
		verdict_t nxt;
		int       gap;
		if (!gapless && $urandom_range(99) < 20) begin
			gap = $urandom_range(4, 1);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.value   <= v;
		in_ch.is_last <= mark;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		nxt.value = v;
		nxt.pal   = fixed ? pal : digits_mirror(v);
		nxt.mark  = mark;
		pending_verdicts.push_back(nxt);
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ch.ready <= gapless || ($urandom_range(99) >= 20);
			end
		end
	end

	always @(posedge clk) begin : check_out
		verdict_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected word: value_echo %0d", out_ch.value_echo);
				fails++;
			end else begin
				want = pending_verdicts.pop_front();
				if (out_ch.value_echo !== want.value) begin
					$error("value_echo: expected %0d, got %0d", want.value, out_ch.value_echo);
					fails++;
				end
				if (out_ch.is_palindrome !== want.pal) begin
					$error("is_palindrome: expected %0b, got %0b", want.pal,
						out_ch.is_palindrome);
					fails++;
				end
				if (out_ch.last_out !== want.mark) begin
					$error("last_out: expected %0b, got %0b", want.mark, out_ch.last_out);
					fails++;
				end
			end
		end
	end

	initial begin
		int    i;
		int    pick;
		logic  neg;
		word_t v;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.value   <= '0;
		in_ch.is_last <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			offer_word(directed_rows[r].value, directed_rows[r].mark,
				directed_rows[r].fixed, directed_rows[r].pal);
		end

		for (i = 0; i < RANDOM_WORDS; i++) begin
			gapless = (i >= 150 && i < 300) || (i >= 400 && i < 460);
			if (i == 400) begin
				hold_req = 1'b1;
			end
			if (i == 550) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_verdicts.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(99);
			neg  = 1'($urandom_range(1));
			if (pick < 35) begin
				v = mirror_value($urandom_range(10, 1), neg);
			end else if (pick < 50) begin
				v = mirror_value($urandom_range(10, 2), neg) + word_t'($urandom_range(9, 1));
			end else if (pick < 75) begin
				v = word_t'($urandom);
			end else if (pick < 90) begin
				v = word_t'($urandom_range(999, 0));
				if (neg) begin
					v = -v;
				end
			end else begin
				case ($urandom_range(4))
					0: v = '0;
					1: v = -word_t'(1);
					2: v = {1'b0, {(VB-1){1'b1}}};
					3: v = {1'b1, {(VB-1){1'b0}}};
					default: v = {1'b1, {(VB-2){1'b0}}, 1'b1};
				endcase
			end
			offer_word(v, ($urandom_range(7) == 0), 1'b0, 1'b0);
		end
		gapless = 1'b0;
		in_ch.valid <= 1'b0;

		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("decimal_palindrome_check_unit test passed");
		end else begin
			$display("decimal_palindrome_check_unit test failed");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("decimal_palindrome_check_unit test failed");
		$finish;
	end

endmodule

// ===== decimal_palindrome_check_unit.f =====
rtl/dpc_pkg.sv
rtl/dpc_ifs.sv
rtl/dpc_dd_stage.sv
rtl/dpc_sym_check.sv
rtl/decimal_palindrome_check_unit.sv
tb/decimal_palindrome_check_unit_test.sv
